// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define SBS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("sbs checker: property violated");

// Next-cycle implication, clocked on i_clk, off while in reset.
`define SBS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("sbs checker: property violated");

`endif

// File: design/sbs_pkg.sv
// Types, constants and per-stage datapath functions of the specular BSDF sampler.
package sbs_pkg;

    localparam int DIR_FRAC_BITS = 14;
    localparam int ONE           = 1 << DIR_FRAC_BITS;

    localparam logic [1:0] MODE_MIRROR  = 2'd0;
    localparam logic [1:0] MODE_REFRACT = 2'd1;
    localparam logic [1:0] MODE_GLASS   = 2'd2;

    localparam logic [1:0] EV_REFL = 2'd0;
    localparam logic [1:0] EV_REFR = 2'd1;
    localparam logic [1:0] EV_TIR  = 2'd2;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_IOR     = 3'd1;
    localparam logic [2:0] REG_REFL_R  = 3'd2;
    localparam logic [2:0] REG_REFL_G  = 3'd3;
    localparam logic [2:0] REG_REFL_B  = 3'd4;
    localparam logic [2:0] REG_TRANS_R = 3'd5;
    localparam logic [2:0] REG_TRANS_G = 3'd6;
    localparam logic [2:0] REG_TRANS_B = 3'd7;

    localparam logic [15:0] RESET_IOR = 16'd6144;
    localparam logic [15:0] IOR_MIN   = 16'd4096;
    localparam logic [15:0] COL_FULL  = 16'hFFFF;
    localparam logic [16:0] PDF_ONE   = 17'd65536;
    localparam logic [23:0] W_MAX     = 24'hFFFFFF;

    // stage map
    localparam int ST_DA0   = 1;
    localparam int DA_STEPS = 17;
    localparam int ST_T2    = 1;
    localparam int ST_ETA   = ST_DA0 + DA_STEPS;
    localparam int ST_ETA2  = ST_ETA + 1;
    localparam int ST_DPROD = ST_ETA2 + 1;
    localparam int ST_DB0   = ST_ETA2 + 1;
    localparam int DB_STEPS = 17;
    localparam int ST_DISC  = ST_DPROD + 1;
    localparam int ST_SQ0   = ST_DISC + 1;
    localparam int SQ_STEPS = 15;
    localparam int SQ_TOP   = 2 * (SQ_STEPS - 1);
    localparam int ST_R0    = ST_DB0 + DB_STEPS;
    localparam int ST_RM    = ST_R0 + 1;
    localparam int ST_DEC   = ST_RM + 1;
    localparam int ST_SEL   = ST_DEC + 1;
    localparam int ST_WMUL  = ST_SEL + 1;
    localparam int ST_WINIT = ST_WMUL + 1;
    localparam int ST_WD0   = ST_WINIT + 1;
    localparam int WD_STEPS = 24;
    localparam int ST_OUT   = ST_WD0 + WD_STEPS;
    localparam int NSTAGE   = ST_OUT + 1;

    typedef struct packed {
        logic signed [15:0] out_dir_x;
        logic signed [15:0] out_dir_y;
        logic signed [15:0] out_dir_z;
        logic [15:0]        random_word;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] in_dir_x;
        logic signed [15:0] in_dir_y;
        logic signed [15:0] in_dir_z;
        logic [16:0]        sample_pdf;
        logic [23:0]        weight_red;
        logic [23:0]        weight_green;
        logic [23:0]        weight_blue;
        logic [1:0]         event_kind;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       mode;
        logic [15:0]      ior;
        logic [2:0][15:0] refl;
        logic [2:0][15:0] trans;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        ior;
        logic [2:0][15:0]   refl;
        logic [2:0][15:0]   trans;
        logic [15:0]        rnd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               entering;
        logic [14:0]        absz;
        logic [14:0]        sin2;
        logic [16:0]        da_rem;
        logic [16:0]        da_q;
        logic [19:0]        eta;
        logic [24:0]        eta2;
        logic [39:0]        dprod;
        logic signed [25:0] disc;
        logic               tir;
        logic [16:0]        t;
        logic [16:0]        t2;
        logic [16:0]        t4;
        logic [16:0]        t5;
        logic [36:0]        db_div;
        logic [20:0]        db_den;
        logic [21:0]        db_rem;
        logic [16:0]        db_q;
        logic [28:0]        sq_v;
        logic [29:0]        sq_res;
        logic [16:0]        r0;
        logic [33:0]        rm;
        logic [16:0]        pdf;
        logic               refr;
        logic [1:0]         kind;
        logic               zero_w;
        logic [34:0]        sx;
        logic [34:0]        sy;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic [14:0]        cosv;
        logic [24:0]        e;
        logic [2:0][15:0]   col;
        logic [2:0][46:0]   wnum;
        logic [39:0]        wden;
        logic [2:0][40:0]   wrem;
        logic [2:0][23:0]   wlow;
        logic [2:0][23:0]   wq;
        logic [2:0]         wsat;
        logic [2:0]         wzero;
        logic [2:0][23:0]   wout;
    } t_item;

    function automatic logic signed [15:0] clamp_dir(input logic signed [15:0] v);
        logic signed [15:0] r;
        r = v;
        if (v > 16'(ONE)) begin
            r = 16'(ONE);
        end else if (v < -16'(ONE)) begin
            r = -16'(ONE);
        end
        return r;
    endfunction

    function automatic logic [14:0] mag15(input logic signed [15:0] v);
        logic [15:0] n;
        n = 16'(-v);
        return v[15] ? n[14:0] : v[14:0];
    endfunction

    // Q1.16 product, rounded
    function automatic logic [16:0] rmul17(input logic [16:0] p, input logic [16:0] q);
        logic [34:0] m;
        m = 35'(p) * 35'(q) + 35'd32768;
        return m[32:16];
    endfunction

    function automatic logic signed [15:0] scale_fin(input logic [34:0] s,
                                                     input logic signed [15:0] v);
        logic [35:0] rr;
        logic [19:0] q;
        logic [15:0] m16;
        rr  = 36'(s) + 36'd32768;
        q   = rr[35:16];
        m16 = (q > 20'(ONE)) ? 16'(ONE) : q[15:0];
        return v[15] ? $signed(m16) : $signed(16'(16'd0 - m16));
    endfunction

    function automatic t_item decode_item(input t_in_item p, input t_cfg c);
        t_item b;
        logic [29:0] zz;
        b          = '0;
        b.mode     = c.mode;
        b.ior      = (c.ior < IOR_MIN) ? IOR_MIN : c.ior;
        b.refl     = c.refl;
        b.trans    = c.trans;
        b.rnd      = p.random_word;
        b.x        = clamp_dir(p.out_dir_x);
        b.y        = clamp_dir(p.out_dir_y);
        b.z        = clamp_dir(p.out_dir_z);
        b.entering = !b.z[15];
        b.absz     = mag15(b.z);
        zz         = 30'(b.absz) * 30'(b.absz);
        b.sin2     = 15'((30'(ONE) * 30'(ONE) - zz) >> DIR_FRAC_BITS);
        b.t        = 17'((17'(ONE) - 17'(b.absz)) << (16 - DIR_FRAC_BITS));
        b.da_rem   = 17'd2048;
        b.da_q     = '0;
        return b;
    endfunction

    function automatic t_item stage_step(input int k, input t_item a);
        t_item       b;
        logic [16:0] ior_half;
        logic [16:0] da_sh;
        logic [4:0]  idx;
        logic [40:0] e41;
        logic [19:0] num;
        logic [20:0] den;
        logic [36:0] dvd;
        logic [21:0] db_sh;
        logic [40:0] dq;
        logic [29:0] sq_bit;
        logic [30:0] sq_sum;
        logic [34:0] rmr;
        logic [18:0] rr;
        logic [16:0] r17;
        logic [15:0] s16;
        logic [47:0] wdv;
        logic [40:0] w_sh;
        b = a;

        if (k >= ST_DA0 && k < ST_DA0 + DA_STEPS) begin
            ior_half = {2'b00, a.ior[15:1]};
            idx      = 5'(DA_STEPS - 1 - (k - ST_DA0));
            da_sh    = {a.da_rem[15:0], ior_half[idx]};
            if (da_sh >= {1'b0, a.ior}) begin
                b.da_rem = da_sh - {1'b0, a.ior};
                b.da_q   = {a.da_q[15:0], 1'b1};
            end else begin
                b.da_rem = da_sh;
                b.da_q   = {a.da_q[15:0], 1'b0};
            end
        end

        if (k == ST_T2) begin
            b.t2 = rmul17(a.t, a.t);
        end
        if (k == ST_T2 + 1) begin
            b.t4 = rmul17(a.t2, a.t2);
        end
        if (k == ST_T2 + 2) begin
            b.t5 = rmul17(a.t4, a.t);
        end

        if (k == ST_ETA) begin
            b.eta = a.entering ? 20'(a.da_q) : {a.ior, 4'b0000};
        end

        if (k == ST_ETA2) begin
            e41      = 41'(a.eta) * 41'(a.eta) + 41'd32768;
            b.eta2   = e41[40:16];
            num      = (a.eta > 20'(PDF_ONE)) ? a.eta - 20'(PDF_ONE) : 20'(PDF_ONE) - a.eta;
            den      = 21'(PDF_ONE) + 21'(a.eta);
            dvd      = (37'(num) << 16) + 37'(den >> 1);
            b.db_div = dvd;
            b.db_den = den;
            b.db_rem = 22'(dvd[36:17]);
            b.db_q   = '0;
        end

        if (k >= ST_DB0 && k < ST_DB0 + DB_STEPS) begin
            idx   = 5'(DB_STEPS - 1 - (k - ST_DB0));
            db_sh = {a.db_rem[20:0], a.db_div[idx]};
            if (db_sh >= {1'b0, a.db_den}) begin
                b.db_rem = db_sh - {1'b0, a.db_den};
                b.db_q   = {a.db_q[15:0], 1'b1};
            end else begin
                b.db_rem = db_sh;
                b.db_q   = {a.db_q[15:0], 1'b0};
            end
        end

        if (k == ST_DPROD) begin
            b.dprod = 40'(a.eta2) * 40'(a.sin2);
        end

        if (k == ST_DISC) begin
            dq       = 41'(a.dprod) + 41'd32768;
            b.disc   = 26'(ONE) - $signed({1'b0, dq[40:16]});
            b.tir    = b.disc[25];
            b.sq_v   = b.tir ? '0 : {b.disc[14:0], 14'd0};
            b.sq_res = '0;
        end

        if (k >= ST_SQ0 && k < ST_SQ0 + SQ_STEPS) begin
            sq_bit = 30'd1 << 5'(SQ_TOP - 2 * (k - ST_SQ0));
            sq_sum = {1'b0, a.sq_res} + {1'b0, sq_bit};
            if ({2'b00, a.sq_v} >= sq_sum) begin
                b.sq_v   = 29'({2'b00, a.sq_v} - sq_sum);
                b.sq_res = (a.sq_res >> 1) + sq_bit;
            end else begin
                b.sq_res = a.sq_res >> 1;
            end
        end

        if (k == ST_R0) begin
            b.r0 = rmul17(a.db_q, a.db_q);
        end

        if (k == ST_RM) begin
            b.rm = 34'(PDF_ONE - a.r0) * 34'(a.t5);
        end

        if (k == ST_DEC) begin
            rmr      = 35'(a.rm) + 35'd32768;
            rr       = 19'(a.r0) + 19'(rmr[34:16]);
            r17      = (rr > 19'(PDF_ONE)) ? PDF_ONE : rr[16:0];
            b.pdf    = PDF_ONE;
            b.refr   = 1'b0;
            b.kind   = EV_REFL;
            b.zero_w = 1'b0;
            if (a.mode != MODE_MIRROR) begin
                if (a.tir) begin
                    b.kind = EV_TIR;
                    if (a.mode == MODE_REFRACT) begin
                        b.zero_w = 1'b1;
                    end
                end else if (a.mode == MODE_REFRACT) begin
                    b.refr = 1'b1;
                end else if ({1'b0, a.rnd} < r17) begin
                    b.pdf = r17;
                end else begin
                    b.refr = 1'b1;
                    b.pdf  = PDF_ONE - r17;
                end
            end
            if (b.refr) begin
                b.kind = EV_REFR;
            end
            b.sx = 35'(a.eta) * 35'(mag15(a.x));
            b.sy = 35'(a.eta) * 35'(mag15(a.y));
        end

        if (k == ST_SEL) begin
            s16 = {1'b0, a.sq_res[14:0]};
            if (a.refr) begin
                b.ox   = scale_fin(a.sx, a.x);
                b.oy   = scale_fin(a.sy, a.y);
                b.oz   = a.entering ? $signed(16'(16'd0 - s16)) : $signed(s16);
                b.cosv = a.sq_res[14:0];
                b.e    = a.eta2;
                b.col  = a.trans;
            end else begin
                b.ox   = -a.x;
                b.oy   = -a.y;
                b.oz   = a.z;
                b.cosv = a.absz;
                b.e    = 25'(PDF_ONE);
                b.col  = a.refl;
            end
        end

        if (k == ST_WMUL) begin
            for (int c = 0; c < 3; c++) begin
                b.wnum[c] = 47'(33'(a.col[c]) * 33'(a.pdf)) << DIR_FRAC_BITS;
            end
            b.wden = 40'(a.cosv) * 40'(a.e);
        end

        if (k == ST_WINIT) begin
            for (int c = 0; c < 3; c++) begin
                wdv        = 48'(a.wnum[c]) + 48'(a.wden >> 1);
                b.wrem[c]  = 41'(wdv[47:24]);
                b.wlow[c]  = wdv[23:0];
                b.wq[c]    = '0;
                b.wsat[c]  = 40'(wdv[47:24]) >= a.wden;
                b.wzero[c] = (a.wnum[c] == '0) || a.zero_w;
            end
        end

        if (k >= ST_WD0 && k < ST_WD0 + WD_STEPS) begin
            idx = 5'(WD_STEPS - 1 - (k - ST_WD0));
            for (int c = 0; c < 3; c++) begin
                w_sh = {a.wrem[c][39:0], a.wlow[c][idx]};
                if (w_sh >= {1'b0, a.wden}) begin
                    b.wrem[c] = w_sh - {1'b0, a.wden};
                    b.wq[c]   = {a.wq[c][22:0], 1'b1};
                end else begin
                    b.wrem[c] = w_sh;
                    b.wq[c]   = {a.wq[c][22:0], 1'b0};
                end
            end
        end

        if (k == ST_OUT) begin
            for (int c = 0; c < 3; c++) begin
                if (a.wzero[c]) begin
                    b.wout[c] = '0;
                end else if (a.wsat[c]) begin
                    b.wout[c] = W_MAX;
                end else begin
                    b.wout[c] = a.wq[c];
                end
            end
        end

        return b;
    endfunction

endpackage

// File: design/sbs_if.sv
// Item and configuration channel interfaces of the specular BSDF sampler.
interface sbs_in_if;
    logic                valid;
    logic                ready;
    sbs_pkg::t_in_item   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sbs_out_if;
    logic                valid;
    logic                ready;
    sbs_pkg::t_out_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [15:0] wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: design/specular_bsdf_sampler_unit.sv
// Specular BSDF sampler top level: mirror, refraction and Schlick glass.
// Depth: 68 register stages; bubbles close up, as a stage moves whenever it is empty.
// Throughput: one item per cycle unless o_out stalls; stages advance on their own.
// Stage count is set by the bit-per-stage dividers (eta, Fresnel, weights).
// Reset (synchronous) clears all stage valids and loads glass, ior 1.5, full colours.
module specular_bsdf_sampler_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    sbs_in_if.sink     i_in,
    sbs_out_if.source  o_out,
    sbs_cfg_if.sink    i_cfg
);

    localparam int NS = sbs_pkg::NSTAGE;

    sbs_pkg::t_cfg  r_cfg;
    sbs_pkg::t_item r_st  [NS];
    logic           r_vld [NS];
    logic [NS-1:0]  w_en;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= sbs_pkg::MODE_GLASS;
            r_cfg.ior   <= sbs_pkg::RESET_IOR;
            r_cfg.refl  <= {3{sbs_pkg::COL_FULL}};
            r_cfg.trans <= {3{sbs_pkg::COL_FULL}};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                sbs_pkg::REG_MODE:    r_cfg.mode     <= i_cfg.wdata[1:0];
                sbs_pkg::REG_IOR:     r_cfg.ior      <= i_cfg.wdata;
                sbs_pkg::REG_REFL_R:  r_cfg.refl[0]  <= i_cfg.wdata;
                sbs_pkg::REG_REFL_G:  r_cfg.refl[1]  <= i_cfg.wdata;
                sbs_pkg::REG_REFL_B:  r_cfg.refl[2]  <= i_cfg.wdata;
                sbs_pkg::REG_TRANS_R: r_cfg.trans[0] <= i_cfg.wdata;
                sbs_pkg::REG_TRANS_G: r_cfg.trans[1] <= i_cfg.wdata;
                sbs_pkg::REG_TRANS_B: r_cfg.trans[2] <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // a stage moves when empty or when the stage after it moves
    assign w_en[NS-1] = !r_vld[NS-1] || o_out.ready;

    generate
        for (genvar g = 0; g < NS - 1; g++) begin : g_en
            assign w_en[g] = !r_vld[g] || w_en[g+1];
        end
    endgenerate

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_vld[0] <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_st[0] <= sbs_pkg::decode_item(i_in.payload, r_cfg);
        end
    end

    generate
        for (genvar k = 1; k < NS; k++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_st[k] <= sbs_pkg::stage_step(k, r_st[k-1]);
                end
            end
        end
    endgenerate

    assign o_out.valid                = r_vld[NS-1];
    assign o_out.payload.in_dir_x     = r_st[NS-1].ox;
    assign o_out.payload.in_dir_y     = r_st[NS-1].oy;
    assign o_out.payload.in_dir_z     = r_st[NS-1].oz;
    assign o_out.payload.sample_pdf   = r_st[NS-1].pdf;
    assign o_out.payload.weight_red   = r_st[NS-1].wout[0];
    assign o_out.payload.weight_green = r_st[NS-1].wout[1];
    assign o_out.payload.weight_blue  = r_st[NS-1].wout[2];
    assign o_out.payload.event_kind   = r_st[NS-1].kind;

endmodule

// File: design/sbs_checker.sv
// Port-level checker for the specular BSDF sampler result channel, with its bind.
`include "assert_macros.svh"

module sbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input sbs_pkg::t_out_item i_payload
);

    `SBS_ASSERT_NXT(a_valid_hold, i_valid && !i_ready, i_valid)
    `SBS_ASSERT_NXT(a_payload_hold, i_valid && !i_ready, $stable(i_payload))
    `SBS_ASSERT_IMP(a_tir_pdf_one, i_valid && i_payload.event_kind == sbs_pkg::EV_TIR, i_payload.sample_pdf == sbs_pkg::PDF_ONE)
    `SBS_ASSERT_IMP(a_pdf_range, i_valid, !i_payload.sample_pdf[16] || i_payload.sample_pdf[15:0] == 16'd0)
    `SBS_ASSERT_IMP(a_refr_pdf_nz, i_valid && i_payload.event_kind == sbs_pkg::EV_REFR, i_payload.sample_pdf != 17'd0)

endmodule

bind specular_bsdf_sampler_unit sbs_checker u_sbs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_out.valid),
    .i_ready   (o_out.ready),
    .i_payload (o_out.payload)
);
